### hw/rtl/all_pole_gammatone_filter_macros.svh
// assertion macros for the all-pole gammatone filter band
// used by modules that check their own control logic
`ifndef ALL_POLE_GAMMATONE_FILTER_MACROS_SVH
`define ALL_POLE_GAMMATONE_FILTER_MACROS_SVH

// same-cycle implication
`define AGF_ASSERT_SAME(label, ck, rs, pre, post, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define AGF_ASSERT_NEXT(label, ck, rs, pre, post, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/agf_pkg.sv
// types, constants and step program for the gammatone filter band
// no dependencies
package agf_pkg;

  localparam int WIDE_W     = 64;
  localparam int B_W        = 33;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PC_W       = 5;

  localparam logic [CFG_ADDR_W-1:0] REG_POLE_K       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN         = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COS_INC      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIN_INC      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_DELAY = 3'd4;

  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_X    = 6'd15;
  localparam logic [5:0] SH_OSC  = 6'd22;
  localparam logic [5:0] SH_K    = 6'd24;
  localparam logic [5:0] SH_MIX  = 6'd30;
  localparam logic [5:0] SH_GAIN = 6'd45;

  localparam logic [PC_W-1:0] PC_LAST = 5'd27;

  typedef enum logic [3:0] {
    A_X, A_H0, A_H1, A_H2, A_H3, A_K, A_K2, A_ACC, A_UR, A_UI, A_FR, A_FI
  } asel_t;

  typedef enum logic [3:0] {
    B_FC, B_K, B_K2, B_K3, B_K4, B_ONE, B_FR, B_FI, B_GAIN, B_COS, B_SIN
  } bsel_t;

  typedef enum logic [1:0] {SAT_ACC, SAT_16, SAT_32, SAT_WIDE} sat_t;
  typedef enum logic [1:0] {SC1, SC4, SC6} scale_t;
  typedef enum logic [1:0] {AP_NONE, AP_LOAD, AP_ADD, AP_SUB} apply_t;

  typedef enum logic [3:0] {
    D_NONE, D_K2, D_K3, D_K4, D_PNEW, D_U, D_Y, D_NR, D_NI
  } dst_t;

  typedef struct packed {
    asel_t      asel;
    bsel_t      bsel;
    logic [5:0] shift;
    sat_t       sat;
    scale_t     scale;
    apply_t     apply;
    dst_t       dst;
    logic       ch;
  } uop_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic scale;
    logic apply;
    logic dly_read;
    logic out_load;
    uop_t uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic mul_busy;
  } dp_sts_t;

  function automatic uop_t mk(asel_t a, bsel_t b, logic [5:0] s, sat_t t, scale_t c,
                              apply_t p, dst_t d, logic ch);
    uop_t u;
    u.asel  = a;
    u.bsel  = b;
    u.shift = s;
    u.sat   = t;
    u.scale = c;
    u.apply = p;
    u.dst   = d;
    u.ch    = ch;
    return u;
  endfunction

  function automatic uop_t prog(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // pole powers
      5'd0:  u = mk(A_K,   B_K,    SH_K,    SAT_WIDE, SC1, AP_NONE, D_K2,   1'b0);
      5'd1:  u = mk(A_K2,  B_K,    SH_K,    SAT_WIDE, SC1, AP_NONE, D_K3,   1'b0);
      5'd2:  u = mk(A_K2,  B_K2,   SH_K,    SAT_WIDE, SC1, AP_NONE, D_K4,   1'b0);
      // real section
      5'd3:  u = mk(A_X,   B_FC,   SH_X,    SAT_ACC,  SC1, AP_LOAD, D_NONE, 1'b0);
      5'd4:  u = mk(A_H0,  B_K,    SH_K,    SAT_ACC,  SC4, AP_ADD,  D_NONE, 1'b0);
      5'd5:  u = mk(A_H1,  B_K2,   SH_K,    SAT_ACC,  SC6, AP_SUB,  D_NONE, 1'b0);
      5'd6:  u = mk(A_H2,  B_K3,   SH_K,    SAT_ACC,  SC4, AP_ADD,  D_NONE, 1'b0);
      5'd7:  u = mk(A_H3,  B_K4,   SH_K,    SAT_ACC,  SC1, AP_SUB,  D_PNEW, 1'b0);
      5'd8:  u = mk(A_H0,  B_ONE,  SH_NONE, SAT_ACC,  SC1, AP_LOAD, D_NONE, 1'b0);
      5'd9:  u = mk(A_H1,  B_K,    SH_K,    SAT_ACC,  SC4, AP_ADD,  D_NONE, 1'b0);
      5'd10: u = mk(A_H2,  B_K2,   SH_K,    SAT_ACC,  SC1, AP_ADD,  D_U,    1'b0);
      // imaginary section
      5'd11: u = mk(A_X,   B_FC,   SH_X,    SAT_ACC,  SC1, AP_LOAD, D_NONE, 1'b1);
      5'd12: u = mk(A_H0,  B_K,    SH_K,    SAT_ACC,  SC4, AP_ADD,  D_NONE, 1'b1);
      5'd13: u = mk(A_H1,  B_K2,   SH_K,    SAT_ACC,  SC6, AP_SUB,  D_NONE, 1'b1);
      5'd14: u = mk(A_H2,  B_K3,   SH_K,    SAT_ACC,  SC4, AP_ADD,  D_NONE, 1'b1);
      5'd15: u = mk(A_H3,  B_K4,   SH_K,    SAT_ACC,  SC1, AP_SUB,  D_PNEW, 1'b1);
      5'd16: u = mk(A_H0,  B_ONE,  SH_NONE, SAT_ACC,  SC1, AP_LOAD, D_NONE, 1'b1);
      5'd17: u = mk(A_H1,  B_K,    SH_K,    SAT_ACC,  SC4, AP_ADD,  D_NONE, 1'b1);
      5'd18: u = mk(A_H2,  B_K2,   SH_K,    SAT_ACC,  SC1, AP_ADD,  D_U,    1'b1);
      // remodulate and gain
      5'd19: u = mk(A_UR,  B_FR,   SH_MIX,  SAT_ACC,  SC1, AP_LOAD, D_NONE, 1'b0);
      5'd20: u = mk(A_UI,  B_FI,   SH_MIX,  SAT_ACC,  SC1, AP_ADD,  D_NONE, 1'b0);
      5'd21: u = mk(A_ACC, B_GAIN, SH_GAIN, SAT_16,   SC1, AP_NONE, D_Y,    1'b0);
      // oscillator turn
      5'd22: u = mk(A_FR,  B_COS,  SH_NONE, SAT_WIDE, SC1, AP_LOAD, D_NONE, 1'b0);
      5'd23: u = mk(A_FI,  B_SIN,  SH_NONE, SAT_WIDE, SC1, AP_SUB,  D_NONE, 1'b0);
      5'd24: u = mk(A_ACC, B_ONE,  SH_OSC,  SAT_32,   SC1, AP_NONE, D_NR,   1'b0);
      5'd25: u = mk(A_FI,  B_COS,  SH_NONE, SAT_WIDE, SC1, AP_LOAD, D_NONE, 1'b0);
      5'd26: u = mk(A_FR,  B_SIN,  SH_NONE, SAT_WIDE, SC1, AP_ADD,  D_NONE, 1'b0);
      5'd27: u = mk(A_ACC, B_ONE,  SH_OSC,  SAT_32,   SC1, AP_NONE, D_NI,   1'b0);
      default: u = mk(A_X, B_ONE,  SH_NONE, SAT_WIDE, SC1, AP_NONE, D_NONE, 1'b0);
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/agf_in_if.sv
// input sample channel: valid, ready and sample payload
// no dependencies
interface agf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               frame_start;

  modport source(output valid, output sample_in, output frame_start, input ready);
  modport sink(input valid, input sample_in, input frame_start, output ready);
endinterface

### hw/rtl/agf_out_if.sv
// output band channel: valid, ready and band payload
// no dependencies
interface agf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] band_out;

  modport source(output valid, output band_out, input ready);
  modport sink(input valid, input band_out, output ready);
endinterface

### hw/rtl/agf_mul.sv
// shared multiplier: 64 x 32 magnitude product in two partial products,
// rounding shift half away from zero and saturation; uses agf_pkg
module agf_mul #(
  parameter int ACC_WIDTH = 56
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [agf_pkg::WIDE_W-1:0] a,
  input  logic signed [agf_pkg::B_W-1:0]    b,
  input  logic [5:0]                        shift,
  input  agf_pkg::sat_t                     sat,
  output logic                              done,
  output logic                              busy,
  output logic signed [agf_pkg::WIDE_W-1:0] result
);

  localparam int HW = agf_pkg::WIDE_W / 2;
  localparam int PW = agf_pkg::WIDE_W + HW;

  logic [agf_pkg::WIDE_W-1:0] amag_c, amag;
  logic [agf_pkg::B_W-1:0]    bneg_c;
  logic [HW-1:0]              bmag;
  logic                       neg;
  logic [5:0]                 sh;
  agf_pkg::sat_t              sat_q;
  logic [2*HW-1:0]            pp_lo, pp_hi;
  logic [PW-1:0]              prod, rmag, half, lim_base, lim, mag;
  logic [6:0]                 wv;
  logic [agf_pkg::WIDE_W-1:0] mag_w;
  logic [4:0]                 stg;

  assign amag_c = a[agf_pkg::WIDE_W-1] ? (~a + 1'b1) : a;
  assign bneg_c = b[agf_pkg::B_W-1] ? (~b + 1'b1) : b;

  always_comb begin
    half = (sh == 6'd0) ? '0 : (PW'(1) << (sh - 6'd1));
    case (sat_q)
      agf_pkg::SAT_ACC: wv = 7'(ACC_WIDTH);
      agf_pkg::SAT_16:  wv = 7'd16;
      agf_pkg::SAT_32:  wv = 7'd32;
      default:          wv = 7'(agf_pkg::WIDE_W);
    endcase
    lim_base = PW'(1) << (wv - 7'd1);
    lim      = neg ? lim_base : lim_base - 1'b1;
    mag      = (rmag > lim) ? lim : rmag;
    mag_w    = mag[agf_pkg::WIDE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg  <= '0;
      done <= 1'b0;
    end else begin
      stg  <= {stg[3:0], start};
      done <= stg[4];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      amag  <= amag_c;
      bmag  <= bneg_c[HW-1:0];
      neg   <= a[agf_pkg::WIDE_W-1] ^ b[agf_pkg::B_W-1];
      sh    <= shift;
      sat_q <= sat;
    end
    if (stg[0]) pp_lo <= amag[HW-1:0] * bmag;
    if (stg[1]) pp_hi <= amag[agf_pkg::WIDE_W-1:HW] * bmag;
    if (stg[2]) prod <= {{HW{1'b0}}, pp_lo} + {pp_hi, {HW{1'b0}}};
    if (stg[3]) rmag <= (prod + half) >> sh;
    if (stg[4]) result <= neg ? $signed(~mag_w + 1'b1) : $signed(mag_w);
  end

  assign busy = |stg;

endmodule

### hw/rtl/agf_datapath.sv
// datapath: configuration, filter state, oscillator, step operands,
// scale and accumulate, delay store; uses agf_pkg and agf_mul
module agf_datapath #(
  parameter int DELAY_DEPTH = 1024,
  parameter int ACC_WIDTH = 56
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [agf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [agf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [15:0]                sample_in,
  input  logic                              frame_start,
  input  agf_pkg::ctrl_cmd_t                cmd,
  output agf_pkg::dp_sts_t                  sts,
  output logic signed [15:0]                band_out
);

  localparam int WW  = agf_pkg::WIDE_W;
  localparam int SCW = WW + 4;
  localparam int PTW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int FW  = $clog2(DELAY_DEPTH + 1);
  localparam int DW  = ((FW > 11) ? FW : 11) + 1;
  localparam logic signed [SCW-1:0] ACC_HI =
    {{(SCW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SCW-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [31:0] OSC_ONE = 32'sh4000_0000;

  function automatic logic signed [WW-1:0] clamp_acc(logic signed [SCW-1:0] v);
    logic signed [SCW-1:0] c;
    c = (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
    return c[WW-1:0];
  endfunction

  logic [23:0]               pole_k;
  logic [31:0]               gain;
  logic signed [23:0]        cos_inc, sin_inc;
  logic [9:0]                output_delay;

  logic signed [15:0]        x, y;
  logic signed [31:0]        osc_re, osc_im, nr;
  logic [23:0]               k2, k3, k4;
  logic signed [ACC_WIDTH-1:0] hist_re [4];
  logic signed [ACC_WIDTH-1:0] hist_im [4];
  logic signed [ACC_WIDTH-1:0] h_sel [4];
  logic signed [ACC_WIDTH-1:0] pnew, u_re, u_im;
  logic signed [WW-1:0]      acc, t_reg, t_next, acc_next, mres, a_op;
  logic signed [agf_pkg::B_W-1:0] b_op;
  logic signed [SCW-1:0]     r_ext, scaled, sum;
  logic                      mul_done, mul_busy;

  logic [15:0]               dmem [DELAY_DEPTH];
  logic [15:0]               rd_data;
  logic [PTW-1:0]            ptr, rd_addr;
  logic [FW-1:0]             fill;
  logic [DW-1:0]             d_ext, d_eff, max_ext, fill_ext, ptr_ext, rd_full;
  logic signed [15:0]        word_out;

  agf_pkg::uop_t u;
  assign u = cmd.uop;

  // operand select
  always_comb begin
    for (int i = 0; i < 4; i++) h_sel[i] = u.ch ? hist_im[i] : hist_re[i];
    case (u.asel)
      agf_pkg::A_X:   a_op = WW'(x);
      agf_pkg::A_H0:  a_op = WW'(h_sel[0]);
      agf_pkg::A_H1:  a_op = WW'(h_sel[1]);
      agf_pkg::A_H2:  a_op = WW'(h_sel[2]);
      agf_pkg::A_H3:  a_op = WW'(h_sel[3]);
      agf_pkg::A_K:   a_op = {{(WW-24){1'b0}}, pole_k};
      agf_pkg::A_K2:  a_op = {{(WW-24){1'b0}}, k2};
      agf_pkg::A_ACC: a_op = acc;
      agf_pkg::A_UR:  a_op = WW'(u_re);
      agf_pkg::A_UI:  a_op = WW'(u_im);
      agf_pkg::A_FR:  a_op = WW'(osc_re);
      agf_pkg::A_FI:  a_op = WW'(osc_im);
      default:        a_op = '0;
    endcase
    case (u.bsel)
      agf_pkg::B_FC:   b_op = u.ch ? agf_pkg::B_W'(osc_im) : agf_pkg::B_W'(osc_re);
      agf_pkg::B_K:    b_op = {{(agf_pkg::B_W-24){1'b0}}, pole_k};
      agf_pkg::B_K2:   b_op = {{(agf_pkg::B_W-24){1'b0}}, k2};
      agf_pkg::B_K3:   b_op = {{(agf_pkg::B_W-24){1'b0}}, k3};
      agf_pkg::B_K4:   b_op = {{(agf_pkg::B_W-24){1'b0}}, k4};
      agf_pkg::B_ONE:  b_op = agf_pkg::B_W'(1);
      agf_pkg::B_FR:   b_op = agf_pkg::B_W'(osc_re);
      agf_pkg::B_FI:   b_op = agf_pkg::B_W'(osc_im);
      agf_pkg::B_GAIN: b_op = {1'b0, gain};
      agf_pkg::B_COS:  b_op = agf_pkg::B_W'(cos_inc);
      agf_pkg::B_SIN:  b_op = agf_pkg::B_W'(sin_inc);
      default:         b_op = '0;
    endcase
  end

  agf_mul #(.ACC_WIDTH(ACC_WIDTH)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.issue),
    .a      (a_op),
    .b      (b_op),
    .shift  (u.shift),
    .sat    (u.sat),
    .done   (mul_done),
    .busy   (mul_busy),
    .result (mres)
  );

  assign sts = '{mul_done: mul_done, mul_busy: mul_busy};

  // scale and accumulate
  always_comb begin
    r_ext = SCW'(mres);
    case (u.scale)
      agf_pkg::SC4: scaled = r_ext <<< 2;
      agf_pkg::SC6: scaled = (r_ext <<< 2) + (r_ext <<< 1);
      default:      scaled = r_ext;
    endcase
    t_next = (u.sat == agf_pkg::SAT_ACC) ? clamp_acc(scaled) : mres;
    sum = (u.apply == agf_pkg::AP_SUB) ? (SCW'(acc) - SCW'(t_reg))
                                       : (SCW'(acc) + SCW'(t_reg));
    case (u.apply)
      agf_pkg::AP_LOAD: acc_next = t_reg;
      agf_pkg::AP_ADD,
      agf_pkg::AP_SUB:  acc_next = (u.sat == agf_pkg::SAT_ACC) ? clamp_acc(sum)
                                                               : sum[WW-1:0];
      default:          acc_next = acc;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pole_k       <= '0;
      gain         <= 32'h4000_0000;
      cos_inc      <= 24'sh40_0000;
      sin_inc      <= '0;
      output_delay <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        agf_pkg::REG_POLE_K:       pole_k       <= cfg_data[23:0];
        agf_pkg::REG_GAIN:         gain         <= cfg_data;
        agf_pkg::REG_COS_INC:      cos_inc      <= cfg_data[23:0];
        agf_pkg::REG_SIN_INC:      sin_inc      <= cfg_data[23:0];
        agf_pkg::REG_OUTPUT_DELAY: output_delay <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // filter and oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      osc_re <= OSC_ONE;
      osc_im <= '0;
      for (int i = 0; i < 4; i++) begin
        hist_re[i] <= '0;
        hist_im[i] <= '0;
      end
    end else if (cmd.accept && frame_start) begin
      osc_re <= OSC_ONE;
      osc_im <= '0;
      for (int i = 0; i < 4; i++) begin
        hist_re[i] <= '0;
        hist_im[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (u.dst == agf_pkg::D_U) begin
        if (u.ch) begin
          for (int i = 3; i > 0; i--) hist_im[i] <= hist_im[i-1];
          hist_im[0] <= pnew;
        end else begin
          for (int i = 3; i > 0; i--) hist_re[i] <= hist_re[i-1];
          hist_re[0] <= pnew;
        end
      end
      if (u.dst == agf_pkg::D_NI) begin
        osc_re <= nr;
        osc_im <= t_reg[31:0];
      end
    end
  end

  // step registers
  always_ff @(posedge clk) begin
    if (cmd.accept) x <= sample_in;
    if (cmd.scale) t_reg <= t_next;
    if (cmd.apply) begin
      acc <= acc_next;
      case (u.dst)
        agf_pkg::D_K2:   k2 <= t_reg[23:0];
        agf_pkg::D_K3:   k3 <= t_reg[23:0];
        agf_pkg::D_K4:   k4 <= t_reg[23:0];
        agf_pkg::D_PNEW: pnew <= acc_next[ACC_WIDTH-1:0];
        agf_pkg::D_U: begin
          if (u.ch) u_im <= acc_next[ACC_WIDTH-1:0];
          else      u_re <= acc_next[ACC_WIDTH-1:0];
        end
        agf_pkg::D_Y:    y  <= t_reg[15:0];
        agf_pkg::D_NR:   nr <= t_reg[31:0];
        default: ;
      endcase
    end
  end

  // delay line
  always_comb begin
    d_ext    = DW'(output_delay);
    max_ext  = DW'(DELAY_DEPTH);
    d_eff    = (d_ext > max_ext) ? max_ext : d_ext;
    fill_ext = DW'(fill);
    ptr_ext  = DW'(ptr);
    rd_full  = (ptr_ext >= d_eff) ? (ptr_ext - d_eff) : (ptr_ext + max_ext - d_eff);
    rd_addr  = rd_full[PTW-1:0];
    if (d_eff == '0)          word_out = y;
    else if (fill_ext < d_eff) word_out = '0;
    else                      word_out = rd_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.dly_read) rd_data <= dmem[rd_addr];
    if (cmd.out_load) dmem[ptr] <= y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else if (cmd.accept && frame_start) begin
      fill <= '0;
    end else if (cmd.out_load) begin
      ptr <= (ptr == PTW'(DELAY_DEPTH - 1)) ? '0 : ptr + 1'b1;
      if (fill_ext < max_ext) fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) band_out <= word_out;
  end

endmodule

### hw/rtl/agf_ctrl.sv
// controller: steps each sample through the shared multiplier program
// and hands the word to the output register; uses agf_pkg and the macros
`include "all_pole_gammatone_filter_macros.svh"

module agf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output agf_pkg::ctrl_cmd_t cmd,
  input  agf_pkg::dp_sts_t   sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_SCALE, ST_APPLY, ST_DREAD, ST_OUT
  } state_t;

  state_t                     state;
  logic [agf_pkg::PC_W-1:0]   pc;
  logic                       load_ok;

  assign load_ok  = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.issue    = (state == ST_ISSUE);
    cmd.scale    = (state == ST_SCALE);
    cmd.apply    = (state == ST_APPLY);
    cmd.dly_read = (state == ST_DREAD);
    cmd.out_load = (state == ST_OUT) && load_ok;
    cmd.uop      = agf_pkg::prog(pc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pc    <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (sts.mul_done) state <= ST_SCALE;
        end
        ST_SCALE: state <= ST_APPLY;
        ST_APPLY: begin
          if (pc == agf_pkg::PC_LAST) begin
            state <= ST_DREAD;
          end else begin
            pc    <= pc + 1'b1;
            state <= ST_ISSUE;
          end
        end
        ST_DREAD: state <= ST_OUT;
        ST_OUT: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AGF_ASSERT_SAME(a_issue_free, clk, rst, cmd.issue, !sts.mul_busy, "multiply issued while busy")
  `AGF_ASSERT_SAME(a_done_wait, clk, rst, sts.mul_done, state == ST_WAIT, "multiply done outside wait")
  `AGF_ASSERT_NEXT(a_accept_start, clk, rst, in_valid && in_ready, state == ST_ISSUE && pc == '0, "accept did not start program")
  `AGF_ASSERT_SAME(a_load_room, clk, rst, cmd.out_load, !out_valid || out_ready, "output word overwritten")

endmodule

### hw/rtl/all_pole_gammatone_filter.sv
// top level of one all-pole gammatone filter band
// uses agf_pkg, agf_in_if, agf_out_if, agf_ctrl, agf_datapath
//
// channel   role   handshake     word
// samples   in     valid/ready   sample_in[15:0] signed, frame_start
// bands     out    valid/ready   band_out[15:0] signed
// cfg       in     cfg_we        cfg_addr[2:0], cfg_data[31:0]
//
// each sample takes 28 multiply steps that go one at a time through the shared
// 64x32 multiplier, plus accept, delay read and output load
// one sample is in flight at a time; the next is taken while the word waits
// a stalled output holds the last step until the output register frees
// reset is synchronous and needs no clearing pass; the delay store is read
// only where written since the last frame start
module all_pole_gammatone_filter #(
  parameter int DELAY_DEPTH = 1024,
  parameter int ACC_WIDTH = 56
) (
  input  logic                           clk,
  input  logic                           rst,
  agf_in_if.sink                         samples,
  agf_out_if.source                      bands,
  input  logic                           cfg_we,
  input  logic [agf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [agf_pkg::CFG_DATA_W-1:0] cfg_data
);

  agf_pkg::ctrl_cmd_t cmd;
  agf_pkg::dp_sts_t   sts;

  agf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (bands.valid),
    .out_ready (bands.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  agf_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .sample_in   (samples.sample_in),
    .frame_start (samples.frame_start),
    .cmd         (cmd),
    .sts         (sts),
    .band_out    (bands.band_out)
  );

endmodule

### tb/sv/all_pole_gammatone_filter_tb.sv
// self-checking testbench for one all-pole gammatone filter band
// depends on agf_pkg, agf_in_if, agf_out_if and all_pole_gammatone_filter
// a bit-exact fixed-point predictor checks every band word in order
`timescale 1ns / 100ps

module all_pole_gammatone_filter_tb;

  localparam int       DLY_DEPTH  = 1024;
  localparam longint   ACC_MAX    = (64'sd1 <<< 55) - 1;
  localparam longint   ACC_MIN    = -(64'sd1 <<< 55);
  localparam int       CYCLE_CAP  = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [agf_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [agf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  agf_in_if  samples_ch();
  agf_out_if bands_ch();

  all_pole_gammatone_filter uut (
    .clk(clk), .rst(rst), .samples(samples_ch), .bands(bands_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint unsigned k_cur, gain_cur;
  longint          cos_cur, sin_cur;
  int unsigned     delay_cur;
  longint          osc_re, osc_im;
  longint          hist_re [0:3];
  longint          hist_im [0:3];
  logic [15:0]     dly_mem [0:DLY_DEPTH-1];
  int unsigned     dly_fill, dly_wr;

  logic signed [15:0] band_expect_q [$];
  int fails = 0;
  int cycles = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int hold_left = 0;

  function automatic longint acc_clip(logic signed [65:0] v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return longint'(v);
  endfunction

  function automatic longint acc_add(longint a, longint b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return acc_clip(s);
  endfunction

  function automatic longint acc_sub(longint a, longint b);
    logic signed [65:0] s;
    s = 66'(a) - 66'(b);
    return acc_clip(s);
  endfunction

  // rounded a*b >> s, half away from zero, saturated to 64 bits
  function automatic longint round_mul(longint a, longint b, int s);
    logic        neg;
    logic [63:0] ua, ub;
    logic [127:0] p, lim;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ua} * {64'd0, ub};
    if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint k_mul(longint p, longint unsigned c);
    return acc_clip(66'(round_mul(p, longint'(c), 24)));
  endfunction

  function automatic longint quad(longint t);
    longint t2;
    t2 = acc_add(t, t);
    return acc_add(t2, t2);
  endfunction

  function automatic longint pole_section(inout longint h [0:3], input longint feed,
                                          input longint unsigned k, k2, k3, k4);
    longint p0, u, t2;
    p0 = acc_add(feed, quad(k_mul(h[0], k)));
    t2 = k_mul(h[1], k2);
    p0 = acc_sub(p0, acc_add(quad(t2), acc_add(t2, t2)));
    p0 = acc_add(p0, quad(k_mul(h[2], k3)));
    p0 = acc_sub(p0, k_mul(h[3], k4));
    u = acc_add(h[0], quad(k_mul(h[1], k)));
    u = acc_add(u, k_mul(h[2], k2));
    h[3] = h[2];
    h[2] = h[1];
    h[1] = h[0];
    h[0] = p0;
    return u;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_band();
    osc_re = 64'sd1 <<< 30;
    osc_im = 0;
    for (int i = 0; i < 4; i++) begin
      hist_re[i] = 0;
      hist_im[i] = 0;
    end
    dly_fill = 0;
  endfunction

  function automatic logic signed [15:0] predict_band(logic signed [15:0] x_in, logic fs);
    longint unsigned k, k2, k3, k4;
    longint x, fr, fi, ur, ui, r, y, nr, ni;
    logic [15:0] word, res;
    int unsigned rd;
    x = longint'(x_in);
    k = k_cur;
    k2 = (k * k + (64'd1 << 23)) >> 24;
    k3 = (k2 * k + (64'd1 << 23)) >> 24;
    k4 = (k2 * k2 + (64'd1 << 23)) >> 24;
    if (fs) clear_band();
    fr = osc_re;
    fi = osc_im;
    ur = pole_section(hist_re, acc_clip(66'(round_mul(x, fr, 15))), k, k2, k3, k4);
    ui = pole_section(hist_im, acc_clip(66'(round_mul(x, fi, 15))), k, k2, k3, k4);
    r = acc_add(acc_clip(66'(round_mul(ur, fr, 30))), acc_clip(66'(round_mul(ui, fi, 30))));
    y = round_mul(r, longint'(gain_cur), 45);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    nr = round_mul(fr * cos_cur - fi * sin_cur, 1, 22);
    ni = round_mul(fi * cos_cur + fr * sin_cur, 1, 22);
    osc_re = clip32(nr);
    osc_im = clip32(ni);
    word = y[15:0];
    if (delay_cur == 0) res = word;
    else if (dly_fill < delay_cur) res = 16'd0;
    else begin
      rd = (dly_wr >= delay_cur) ? dly_wr - delay_cur : dly_wr + DLY_DEPTH - delay_cur;
      res = dly_mem[rd % DLY_DEPTH];
    end
    dly_mem[dly_wr] = word;
    dly_wr = (dly_wr + 1) % DLY_DEPTH;
    if (dly_fill < DLY_DEPTH) dly_fill++;
    return res;
  endfunction

  task automatic write_reg(logic [agf_pkg::CFG_ADDR_W-1:0] idx,
                           logic [agf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      agf_pkg::REG_POLE_K:       k_cur = val[23:0];
      agf_pkg::REG_GAIN:         gain_cur = val;
      agf_pkg::REG_COS_INC:      cos_cur = longint'($signed(val[23:0]));
      agf_pkg::REG_SIN_INC:      sin_cur = longint'($signed(val[23:0]));
      agf_pkg::REG_OUTPUT_DELAY: delay_cur = val[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_band(logic [23:0] k, logic [31:0] g, logic [23:0] c, logic [23:0] s,
                          logic [9:0] d);
    write_reg(agf_pkg::REG_POLE_K, 32'(k));
    write_reg(agf_pkg::REG_GAIN, g);
    write_reg(agf_pkg::REG_COS_INC, 32'(c));
    write_reg(agf_pkg::REG_SIN_INC, 32'(s));
    write_reg(agf_pkg::REG_OUTPUT_DELAY, 32'(d));
  endtask

  task automatic drain();
    samples_ch.valid <= 1'b0;
    while (band_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] x, logic fs);
    while ($urandom_range(99) < src_idle) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.sample_in <= x;
    samples_ch.frame_start <= fs;
    do @(posedge clk); while (!samples_ch.ready);
    band_expect_q.push_back(predict_band(x, fs));
  endtask

  // receiver: check each accepted word, then choose ready for the next edge
  always @(posedge clk) begin
    if (!rst && bands_ch.valid && bands_ch.ready) begin
      if (band_expect_q.size() == 0) begin
        $display("%0t: unexpected band word, expected none, actual %0d", $time,
                 bands_ch.band_out);
        fails++;
      end else begin
        if (bands_ch.band_out !== band_expect_q[0]) begin
          $display("%0t: band_out mismatch, expected %0d, actual %0d", $time,
                   band_expect_q[0], bands_ch.band_out);
          fails++;
        end
        void'(band_expect_q.pop_front());
      end
    end
    bands_ch.ready <= !rst && hold_left == 0 && ($urandom_range(99) >= snk_stall);
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_extremes();
    logic signed [15:0] vals [6] = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0001,
                                     -16'sh0001, 16'sh4000};
    foreach (vals[i]) send_sample(vals[i], i == 0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sh8000, 1'b0);
    drain();
    set_band(24'hffffff, 32'hffffffff, 24'h7fffff, 24'h800000, 10'd0);
    foreach (vals[i]) send_sample(vals[i], 1'b0);
    send_sample(16'sh7fff, 1'b1);
    drain();
  endtask

  task automatic test_delay_fill();
    set_band(24'd15000000, 32'h40000000, 24'h3b0000, 24'h180000, 10'd3);
    for (int i = 0; i < 6; i++) send_sample(16'($urandom), i == 0);
    drain();
    write_reg(agf_pkg::REG_OUTPUT_DELAY, 32'd5);
    for (int i = 0; i < 4; i++) send_sample(16'($urandom), 1'b0);
    send_sample(16'sh1234, 1'b1);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall, int d_max);
    src_idle = idle;
    snk_stall = stall;
    set_band(24'($urandom_range(24'hffffff, 24'hd00000)), $urandom,
             24'($urandom), 24'($urandom), 10'($urandom_range(d_max)));
    for (int i = 0; i < n; i++) send_sample(16'($urandom), $urandom_range(59) == 0);
    drain();
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    snk_stall = 0;
    @(posedge clk);
    hold_left <= 3000;
    for (int i = 0; i < 8; i++) send_sample(16'($urandom), 1'b0);
    drain();
  endtask

  task automatic test_long_delay();
    src_idle = 27;
    snk_stall = 27;
    set_band(24'd16000000, 32'h20000000, 24'h3f0000, 24'h080000, 10'd600);
    for (int i = 0; i < 620; i++) send_sample(16'($urandom), i == 0);
    drain();
  endtask

  initial begin
    samples_ch.valid = 1'b0;
    samples_ch.sample_in = '0;
    samples_ch.frame_start = 1'b0;
    bands_ch.ready = 1'b0;
    k_cur = 0;
    gain_cur = 64'd1073741824;
    cos_cur = 4194304;
    sin_cur = 0;
    delay_cur = 0;
    clear_band();
    for (int i = 0; i < DLY_DEPTH; i++) dly_mem[i] = '0;
    dly_wr = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_extremes();
    test_delay_fill();
    test_random(90, 0, 0, 30);
    test_random(90, 76, 0, 10);
    test_random(90, 0, 76, 0);
    test_random(90, 27, 27, 40);
    test_backpressure();
    test_long_delay();

    repeat (400) @(posedge clk);
    if (fails == 0 && band_expect_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
